/* src/cfs_pkg.sv */
`default_nettype none

package cfs_pkg;

	typedef enum logic [2:0] {
		MODE_OFF        = 3'd0,
		MODE_DRY        = 3'd1,
		MODE_HUMIDIFY   = 3'd2,
		MODE_COOL       = 3'd3,
		MODE_HEAT       = 3'd4,
		MODE_FOLLOW_MAX = 3'd5
	} fan_mode_t;

	typedef enum logic [2:0] {
		REG_FAN_MODE          = 3'd0,
		REG_DAY_TARGET_TEMP   = 3'd1,
		REG_NIGHT_TARGET_TEMP = 3'd2,
		REG_DAY_TARGET_HUM    = 3'd3,
		REG_NIGHT_TARGET_HUM  = 3'd4,
		REG_NIGHT_START_TIME  = 3'd5,
		REG_DAY_START_TIME    = 3'd6,
		REG_MAX_SPEED_PAIR    = 3'd7
	} reg_index_t;

	localparam int unsigned CFG_DATA_W = 15;

	localparam logic [10:0] NIGHT_START_RESET = 11'd1320;
	localparam logic [10:0] DAY_START_RESET   = 11'd360;

	// step sizes
	localparam logic signed [8:0] STEP_PASSED    = 9'sd10;
	localparam logic signed [8:0] STEP_IMPROVING = 9'sd1;
	localparam logic signed [8:0] STEP_RISE      = 9'sd2;

	// duty = 25 + floor((speed - 1) * 230 / 99), with / 99 done as
	// a multiply by ceil(2^21 / 99) = 21184, folded with 230
	localparam logic [22:0] DUTY_MULT  = 23'd4872320;
	localparam int unsigned DUTY_SHIFT = 21;
	localparam logic [9:0]  DUTY_BASE  = 10'd25;
	localparam logic [9:0]  DUTY_MAX   = 10'd255;

	typedef struct packed {
		fan_mode_t          fan_mode;
		logic signed [14:0] day_target_temp;
		logic signed [14:0] night_target_temp;
		logic [13:0]        day_target_humidity;
		logic [13:0]        night_target_humidity;
		logic [10:0]        night_start_time;
		logic [10:0]        day_start_time;
		logic [13:0]        max_speed_pair;
	} cfg_t;

	typedef struct packed {
		logic [6:0]         fan_speed;
		logic signed [16:0] previous_error;
		logic               error_seen;
	} ctl_state_t;

	typedef struct packed {
		logic [6:0]         speed;
		logic               is_day;
		logic               err_upd;
		logic signed [16:0] error;
	} step_res_t;

endpackage

`default_nettype wire

/* src/cfs_in_if.sv */
`default_nettype none

interface cfs_in_if;
	logic               valid;
	logic               ready;
	logic [10:0]        time_of_day;
	logic signed [14:0] temperature;
	logic [13:0]        humidity;

	modport source (output valid, output time_of_day, output temperature, output humidity,
		input ready);
	modport sink (input valid, input time_of_day, input temperature, input humidity,
		output ready);
endinterface

`default_nettype wire

/* src/cfs_out_if.sv */
`default_nettype none

interface cfs_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  pwm_duty;
	logic [6:0]  speed_percent;
	logic        is_day;

	modport source (output valid, output pwm_duty, output speed_percent, output is_day,
		input ready);
	modport sink (input valid, input pwm_duty, input speed_percent, input is_day,
		output ready);
endinterface

`default_nettype wire

/* src/cfs_cfg_regs.sv */
`default_nettype none

module cfs_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire cfs_pkg::reg_index_t               wr_index,
	input  wire logic [cfs_pkg::CFG_DATA_W-1:0]    wr_data,
	output cfs_pkg::cfg_t                          cfg
);
	import cfs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fan_mode              <= MODE_OFF;
			cfg_q.day_target_temp       <= '0;
			cfg_q.night_target_temp     <= '0;
			cfg_q.day_target_humidity   <= '0;
			cfg_q.night_target_humidity <= '0;
			cfg_q.night_start_time      <= NIGHT_START_RESET;
			cfg_q.day_start_time        <= DAY_START_RESET;
			cfg_q.max_speed_pair        <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FAN_MODE:          cfg_q.fan_mode <= fan_mode_t'(wr_data[2:0]);
				REG_DAY_TARGET_TEMP:   cfg_q.day_target_temp <= wr_data[14:0];
				REG_NIGHT_TARGET_TEMP: cfg_q.night_target_temp <= wr_data[14:0];
				REG_DAY_TARGET_HUM:    cfg_q.day_target_humidity <= wr_data[13:0];
				REG_NIGHT_TARGET_HUM:  cfg_q.night_target_humidity <= wr_data[13:0];
				REG_NIGHT_START_TIME:  cfg_q.night_start_time <= wr_data[10:0];
				REG_DAY_START_TIME:    cfg_q.day_start_time <= wr_data[10:0];
				REG_MAX_SPEED_PAIR:    cfg_q.max_speed_pair <= wr_data[13:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* src/cfs_speed_step.sv */
`default_nettype none

module cfs_speed_step (
	input  cfs_pkg::cfg_t             cfg,
	input  cfs_pkg::ctl_state_t       state,
	input  wire logic [10:0]          time_of_day,
	input  wire logic signed [14:0]   temperature,
	input  wire logic [13:0]          humidity,
	output cfs_pkg::step_res_t        res
);
	import cfs_pkg::*;

	logic               day;
	logic signed [14:0] tgt_t;
	logic [13:0]        tgt_h;
	logic [6:0]         maxs;
	logic signed [16:0] err_t;
	logic signed [16:0] err_h;
	logic signed [16:0] err;
	logic signed [17:0] change;
	logic               down;
	logic               passed;
	logic               improving;
	logic signed [8:0]  sp_cur;
	logic signed [8:0]  sp_step;
	logic signed [8:0]  sp_floor;
	logic signed [8:0]  sp_raw;
	logic signed [8:0]  sp_max;
	logic [6:0]         speed_out;
	logic               err_upd;

	assign day = !(time_of_day > cfg.night_start_time || time_of_day < cfg.day_start_time);
	assign tgt_t = day ? cfg.day_target_temp : cfg.night_target_temp;
	assign tgt_h = day ? cfg.day_target_humidity : cfg.night_target_humidity;
	assign maxs = day ? cfg.max_speed_pair[6:0] : cfg.max_speed_pair[13:7];

	// zero target disables the error
	assign err_t = (tgt_t == '0) ? '0 : 17'(temperature) - 17'(tgt_t);
	assign err_h = (tgt_h == '0) ? '0 : $signed(17'(humidity)) - $signed(17'(tgt_h));

	assign down = (cfg.fan_mode == MODE_DRY) || (cfg.fan_mode == MODE_COOL);
	assign err = ((cfg.fan_mode == MODE_DRY) || (cfg.fan_mode == MODE_HUMIDIFY))
		? err_h : err_t;
	assign change = state.error_seen ? 18'(err) - 18'(state.previous_error) : '0;

	assign passed = down ? (err < 0) : (err > 0);
	assign improving = down ? (change < 0) : (change > 0);

	assign sp_cur = $signed({2'b00, state.fan_speed});
	assign sp_max = $signed({2'b00, maxs});

	always_comb begin
		priority if (passed) begin
			sp_step = sp_cur - STEP_PASSED;
		end else if (improving) begin
			sp_step = sp_cur - STEP_IMPROVING;
		end else begin
			sp_step = sp_cur + STEP_RISE;
		end
	end

	assign sp_floor = (sp_step < 0) ? '0 : sp_step;

	always_comb begin
		err_upd = 1'b0;
		unique case (cfg.fan_mode)
			MODE_DRY, MODE_HUMIDIFY, MODE_COOL, MODE_HEAT: begin
				sp_raw = sp_floor;
				err_upd = 1'b1;
			end
			MODE_FOLLOW_MAX: sp_raw = sp_max;
			default:         sp_raw = '0;
		endcase
	end

	assign speed_out = (sp_raw > sp_max) ? maxs : sp_raw[6:0];
	assign res = {speed_out, day, err_upd, err};

endmodule

`default_nettype wire

/* src/cfs_duty_map.sv */
`default_nettype none

module cfs_duty_map (
	input  wire logic [6:0] speed,
	output logic [7:0]      pwm_duty
);
	import cfs_pkg::*;

	logic [6:0]  sm1;
	logic [29:0] prod;
	logic [9:0]  duty;

	assign sm1 = speed - 7'd1;
	assign prod = 30'(sm1) * 30'(DUTY_MULT);
	assign duty = DUTY_BASE + 10'(prod[29:DUTY_SHIFT]);

	// speeds above 100 saturate
	assign pwm_duty = (speed == '0) ? '0 : ((duty > DUTY_MAX) ? DUTY_MAX[7:0] : duty[7:0]);

endmodule

`default_nettype wire

/* src/climate_fan_speed_stepper.sv */
`default_nettype none

// path: an update is held in the input stage, then in the result stage, before its result transfers
// throughput: one update per cycle while drive back-pressure does not stall the result stage
// reset: arst_n clears fan speed, last error and the first-update flag,
// configuration returns to its reset values and both pipeline stages empty
module climate_fan_speed_stepper (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	cfs_in_if.sink                              update,
	cfs_out_if.source                           drive,
	input  wire logic                           wr_en,
	input  wire cfs_pkg::reg_index_t            wr_index,
	input  wire logic [cfs_pkg::CFG_DATA_W-1:0] wr_data
);
	import cfs_pkg::*;

	cfg_t       cfg;
	ctl_state_t state;
	step_res_t  res;

	// input stage
	logic               valid_s1;
	logic [10:0]        time_s1;
	logic signed [14:0] temp_s1;
	logic [13:0]        hum_s1;

	// result stage
	logic               valid_s2;
	logic [7:0]         duty_s2;
	logic [6:0]         speed_s2;
	logic               day_s2;

	// loop state
	logic [6:0]         fan_speed_q;
	logic signed [16:0] prev_err_q;
	logic               err_seen_q;

	logic [7:0]         duty_next;
	logic               adv;
	logic               take;

	cfs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	assign state = {fan_speed_q, prev_err_q, err_seen_q};

	// speed step works on the held update against the live loop state
	cfs_speed_step u_step (
		.cfg         (cfg),
		.state       (state),
		.time_of_day (time_s1),
		.temperature (temp_s1),
		.humidity    (hum_s1),
		.res         (res)
	);

	cfs_duty_map u_duty (
		.speed    (res.speed),
		.pwm_duty (duty_next)
	);

	// result register free, or being emptied this cycle
	assign adv = !valid_s2 || drive.ready;
	assign update.ready = !valid_s1 || adv;
	assign take = update.valid && update.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			time_s1 <= update.time_of_day;
			temp_s1 <= update.temperature;
			hum_s1  <= update.humidity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			duty_s2  <= duty_next;
			speed_s2 <= res.speed;
			day_s2   <= res.is_day;
		end
	end

	// the loop state moves exactly once per update, when it leaves the input stage,
	// so the next update in line already sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_speed_q <= '0;
			prev_err_q  <= '0;
			err_seen_q  <= 1'b0;
		end else if (adv && valid_s1) begin
			fan_speed_q <= res.speed;
			if (res.err_upd) begin
				prev_err_q <= res.error;
				err_seen_q <= 1'b1;
			end
		end
	end

	assign drive.valid         = valid_s2;
	assign drive.pwm_duty      = duty_s2;
	assign drive.speed_percent = speed_s2;
	assign drive.is_day        = day_s2;

endmodule

`default_nettype wire

/* dv/climate_fan_speed_stepper_tb.sv */
`default_nettype none

module climate_fan_speed_stepper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfs_pkg::*;

	// mode codes the block has no meaning for, they must behave as off
	localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	// speed steps and duty mapping
	localparam int STEP_DOWN_PASSED = 10;
	localparam int STEP_DOWN_BETTER = 1;
	localparam int STEP_UP          = 2;
	localparam int DUTY_FLOOR       = 25;
	localparam int DUTY_CEIL        = 255;
	localparam int DUTY_SPAN        = 230;
	localparam int SPEED_STEPS      = 99;

	// cycles with no transfer or register write before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	// mismatch lines printed before going quiet (counting carries on)
	localparam int REPORT_CAP  = 50;

	typedef struct {
		logic [2:0]         mode;
		logic signed [14:0] day_temp;
		logic signed [14:0] night_temp;
		logic [13:0]        day_hum;
		logic [13:0]        night_hum;
		logic [10:0]        night_start;
		logic [10:0]        day_start;
		logic [13:0]        max_pair;
	} climate_cfg_t;

	typedef struct {
		logic [7:0] duty;
		logic [6:0] speed;
		logic       day;
	} fan_drive_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	reg_index_t wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	cfs_in_if  update_bus ();
	cfs_out_if drive_bus ();

	climate_fan_speed_stepper u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (update_bus),
		.drive    (drive_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #1 clk = ~clk;

	// shadow of the block: register copy and controller state
	climate_cfg_t live_cfg;
	logic [6:0]         fan_speed_q   = '0;
	logic signed [16:0] last_error    = '0;
	logic               error_seen    = 1'b0;

	fan_drive_t pending_drive[$];

	int mismatches       = 0;
	int updates_sent     = 0;
	int results_checked  = 0;
	int settings_loaded  = 0;
	int quiet_cycles     = 0;
	// 1-in-n chance per item / per cycle of starting an idle burst, 0 means none
	int source_idle_rate = 4;
	int sink_idle_rate   = 4;

	function automatic climate_cfg_t power_on_cfg();
		climate_cfg_t c;
		c.mode        = MODE_OFF;
		c.day_temp    = '0;
		c.night_temp  = '0;
		c.day_hum     = '0;
		c.night_hum   = '0;
		c.night_start = NIGHT_START_RESET;
		c.day_start   = DAY_START_RESET;
		c.max_pair    = '0;
		return c;
	endfunction

	// register write as seen by the block
	function automatic void apply_write(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_FAN_MODE:          live_cfg.mode        = val[2:0];
			REG_DAY_TARGET_TEMP:   live_cfg.day_temp    = val[14:0];
			REG_NIGHT_TARGET_TEMP: live_cfg.night_temp  = val[14:0];
			REG_DAY_TARGET_HUM:    live_cfg.day_hum     = val[13:0];
			REG_NIGHT_TARGET_HUM:  live_cfg.night_hum   = val[13:0];
			REG_NIGHT_START_TIME:  live_cfg.night_start = val[10:0];
			REG_DAY_START_TIME:    live_cfg.day_start   = val[10:0];
			REG_MAX_SPEED_PAIR:    live_cfg.max_pair    = val[13:0];
			default: ;
		endcase
	endfunction

	// one control update: advances the shadow state and returns the drive it causes
	function automatic fan_drive_t step_fan(input logic [10:0] tod,
		input logic signed [14:0] temp, input logic [13:0] hum);
		fan_drive_t res;
		logic day, lower;
		logic signed [14:0] tgt_t;
		logic [13:0] tgt_h;
		logic [6:0] cap;
		logic signed [16:0] err_t, err_h, err;
		int spd, delta, duty;

		// night wins outside the [day start, night start] window
		day   = !(tod > live_cfg.night_start || tod < live_cfg.day_start);
		tgt_t = day ? live_cfg.day_temp : live_cfg.night_temp;
		tgt_h = day ? live_cfg.day_hum : live_cfg.night_hum;
		cap   = day ? live_cfg.max_pair[6:0] : live_cfg.max_pair[13:7];

		// a zero target switches that error off
		if (tgt_t == 0)
			err_t = '0;
		else
			err_t = 17'(int'(temp) - int'(tgt_t));
		if (tgt_h == 0)
			err_h = '0;
		else
			err_h = 17'(int'(hum) - int'(tgt_h));

		spd = fan_speed_q;
		case (live_cfg.mode)
			MODE_DRY, MODE_HUMIDIFY, MODE_COOL, MODE_HEAT: begin
				lower = (live_cfg.mode == MODE_DRY) || (live_cfg.mode == MODE_COOL);
				if (live_cfg.mode == MODE_DRY || live_cfg.mode == MODE_HUMIDIFY)
					err = err_h;
				else
					err = err_t;
				// no trend on the first stepped update
				delta = error_seen ? int'(err) - int'(last_error) : 0;
				last_error = err;
				error_seen = 1'b1;
				if (lower ? (err < 0) : (err > 0))
					spd -= STEP_DOWN_PASSED;
				else if (lower ? (delta < 0) : (delta > 0))
					spd -= STEP_DOWN_BETTER;
				else
					spd += STEP_UP;
				if (spd < 0)
					spd = 0;
			end
			MODE_FOLLOW_MAX: spd = cap;
			default: spd = 0;
		endcase
		if (spd > cap)
			spd = cap;
		fan_speed_q = 7'(spd);

		duty = (spd == 0) ? 0 : DUTY_FLOOR + ((spd - 1) * DUTY_SPAN) / SPEED_STEPS;
		if (duty > DUTY_CEIL)
			duty = DUTY_CEIL;

		res.duty  = 8'(duty);
		res.speed = 7'(spd);
		res.day   = day;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// sampled at the rising edge: register writes, update transfers feed the
	// shadow, drive transfers are checked against the oldest expectation
	always @(posedge clk) begin
		fan_drive_t want;
		if (arst_n) begin
			if (wr_en)
				apply_write(wr_index, wr_data);
			if (update_bus.valid && update_bus.ready) begin
				pending_drive.push_back(step_fan(update_bus.time_of_day,
					update_bus.temperature, update_bus.humidity));
				updates_sent++;
			end
			if (drive_bus.valid && drive_bus.ready) begin
				if (pending_drive.size() == 0) begin
					report_mismatch($sformatf("result with nothing outstanding: duty %0d speed %0d day %0b",
						drive_bus.pwm_duty, drive_bus.speed_percent, drive_bus.is_day));
				end else begin
					want = pending_drive.pop_front();
					if (drive_bus.pwm_duty !== want.duty)
						report_mismatch($sformatf("result %0d pwm_duty got %0d expected %0d",
							results_checked, drive_bus.pwm_duty, want.duty));
					if (drive_bus.speed_percent !== want.speed)
						report_mismatch($sformatf("result %0d speed_percent got %0d expected %0d",
							results_checked, drive_bus.speed_percent, want.speed));
					if (drive_bus.is_day !== want.day)
						report_mismatch($sformatf("result %0d is_day got %0b expected %0b",
							results_checked, drive_bus.is_day, want.day));
				end
				results_checked++;
			end
		end
	end

	// watchdog: any transfer or register write counts as progress
	always @(posedge clk) begin
		if (!arst_n || wr_en || (update_bus.valid && update_bus.ready) ||
			(drive_bus.valid && drive_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("no transfer for %0d cycles, %0d results still outstanding",
				quiet_cycles, pending_drive.size());
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side back-pressure in bursts
	initial begin
		int stall_left;
		stall_left = 0;
		drive_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				drive_bus.ready <= 1'b0;
				stall_left--;
			end else if (sink_idle_rate != 0 && $urandom_range(0, sink_idle_rate - 1) == 0) begin
				drive_bus.ready <= 1'b0;
				stall_left = $urandom_range(1, 17) - 1;
			end else begin
				drive_bus.ready <= 1'b1;
			end
		end
	end

	// one update transfer; entered and left at a falling edge, valid left high
	task automatic send_update(input logic [10:0] tod, input logic signed [14:0] temp,
		input logic [13:0] hum);
		int gap;
		gap = 0;
		if (source_idle_rate != 0 && $urandom_range(0, source_idle_rate - 1) == 0)
			gap = $urandom_range(1, 17);
		if (gap != 0) begin
			update_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		update_bus.valid       <= 1'b1;
		update_bus.time_of_day <= tod;
		update_bus.temperature <= temp;
		update_bus.humidity    <= hum;
		@(posedge clk);
		while (!update_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// drop valid and wait until every drive has come back plus pipeline slack
	task automatic settle();
		update_bus.valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic put_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
	endtask

	// back-to-back writes of every register, only while the block is idle
	task automatic load_settings(input climate_cfg_t c);
		put_reg(REG_FAN_MODE, 15'(c.mode));
		put_reg(REG_DAY_TARGET_TEMP, c.day_temp);
		put_reg(REG_NIGHT_TARGET_TEMP, c.night_temp);
		put_reg(REG_DAY_TARGET_HUM, 15'(c.day_hum));
		put_reg(REG_NIGHT_TARGET_HUM, 15'(c.night_hum));
		put_reg(REG_NIGHT_START_TIME, 15'(c.night_start));
		put_reg(REG_DAY_START_TIME, 15'(c.day_start));
		put_reg(REG_MAX_SPEED_PAIR, 15'(c.max_pair));
		wr_en <= 1'b0;
		settings_loaded++;
	endtask

	function automatic logic signed [14:0] pick_temp_target();
		case ($urandom_range(0, 7))
			0: return 15'(0);
			1: return 15'(-4500);
			2: return 15'(13000);
			3: return 15'(-16384);
			4: return 15'(16383);
			default: return 15'(int'($urandom_range(0, 17500)) - 4500);
		endcase
	endfunction

	function automatic logic [13:0] pick_hum_target();
		case ($urandom_range(0, 5))
			0: return 14'd0;
			1: return 14'd10000;
			2: return 14'h3FFF;
			default: return 14'($urandom_range(1, 10000));
		endcase
	endfunction

	function automatic logic [10:0] pick_clock();
		case ($urandom_range(0, 7))
			0: return 11'd0;
			1: return 11'd1439;
			2: return 11'h7FF;
			default: return 11'($urandom_range(0, 1439));
		endcase
	endfunction

	function automatic int pick_rate();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 9;
		endcase
	endfunction

	function automatic climate_cfg_t random_settings();
		climate_cfg_t c;
		// mostly the stepping modes, where the state matters
		if ($urandom_range(0, 3) != 0)
			c.mode = 3'($urandom_range(MODE_DRY, MODE_HEAT));
		else
			c.mode = 3'($urandom_range(MODE_OFF, MODE_UNUSED_HI));
		c.day_temp    = pick_temp_target();
		c.night_temp  = pick_temp_target();
		c.day_hum     = pick_hum_target();
		c.night_hum   = pick_hum_target();
		c.night_start = pick_clock();
		c.day_start   = pick_clock();
		case ($urandom_range(0, 5))
			0: c.max_pair = 14'h3FFF;
			1: c.max_pair = {7'd100, 7'd100};
			2: c.max_pair = '0;
			default: c.max_pair = 14'($urandom());
		endcase
		return c;
	endfunction

	// mostly near the day/night boundaries or inside a normal day
	function automatic logic [10:0] pick_time(input climate_cfg_t c);
		case ($urandom_range(0, 9))
			0: return 11'($urandom());
			1: return 11'(int'(c.day_start) - 1 + int'($urandom_range(0, 2)));
			2: return 11'(int'(c.night_start) - 1 + int'($urandom_range(0, 2)));
			default: return 11'($urandom_range(0, 1439));
		endcase
	endfunction

	// random walk around the target, pulled back when it strays too far
	function automatic int wander(input int v, input int centre, input int lo, input int hi);
		int w;
		w = v + int'($urandom_range(0, 400)) - 200;
		if (w > centre + 1500 || w < centre - 1500)
			w = centre;
		if (w < lo)
			w = lo;
		if (w > hi)
			w = hi;
		return w;
	endfunction

	// readings drift around the active target so every stepping branch comes up;
	// a quarter are raw field values
	task automatic stream_updates(input climate_cfg_t c, input int count);
		int temp_walk, hum_walk;
		logic [10:0] tod;
		logic day;
		temp_walk = c.day_temp;
		hum_walk  = c.day_hum;
		for (int i = 0; i < count; i++) begin
			tod = pick_time(c);
			day = !(tod > c.night_start || tod < c.day_start);
			temp_walk = wander(temp_walk, day ? c.day_temp : c.night_temp, -16384, 16383);
			hum_walk  = wander(hum_walk, day ? c.day_hum : c.night_hum, 0, 16383);
			if ($urandom_range(0, 3) == 0)
				send_update(tod, 15'($urandom()), 14'($urandom()));
			else
				send_update(tod, 15'(temp_walk), 14'(hum_walk));
		end
	endtask

	// fan off with power-on registers, day window edges with reset times
	task automatic test_power_on_defaults();
		send_update(11'd0, 15'(-16384), 14'd0);
		send_update(11'd360, 15'(16383), 14'h3FFF);
		send_update(11'd1320, 15'(0), 14'd10000);
		send_update(11'd1321, 15'(-4500), 14'd0);
	endtask

	// follow maximum, with the top speed saturating the duty and the lowest speed
	task automatic test_follow_maximum();
		climate_cfg_t c;
		c = power_on_cfg();
		c.mode     = MODE_FOLLOW_MAX;
		c.max_pair = {7'd100, 7'd127};
		settle();
		load_settings(c);
		send_update(11'd720, 15'(13000), 14'd10000);
		send_update(11'h7FF, 15'(16383), 14'h3FFF);
		c.max_pair = {7'd0, 7'd1};
		settle();
		load_settings(c);
		send_update(11'd720, 15'(-4500), 14'd0);
		send_update(11'd100, 15'(0), 14'd5000);
	endtask

	// temperature down then up: first update, better trend, target passed,
	// worse trend, disabled night target
	task automatic test_temperature_stepping();
		climate_cfg_t c;
		c = power_on_cfg();
		c.mode       = MODE_COOL;
		c.day_temp   = 15'(2000);
		c.night_temp = 15'(0);
		c.max_pair   = 14'h3FFF;
		settle();
		load_settings(c);
		send_update(11'd720, 15'(2500), 14'd0);
		send_update(11'd720, 15'(2400), 14'd0);
		send_update(11'd720, 15'(1000), 14'd0);
		send_update(11'd720, 15'(3000), 14'd0);
		send_update(11'd100, 15'(3000), 14'd0);
		c.mode = MODE_HEAT;
		settle();
		load_settings(c);
		send_update(11'd720, 15'(1500), 14'd0);
		send_update(11'd720, 15'(1600), 14'd0);
		send_update(11'd720, 15'(2600), 14'd0);
	endtask

	task automatic test_humidity_stepping();
		climate_cfg_t c;
		c = power_on_cfg();
		c.mode      = MODE_HUMIDIFY;
		c.day_hum   = 14'd5000;
		c.night_hum = 14'd10000;
		c.max_pair  = {7'd50, 7'd100};
		settle();
		load_settings(c);
		send_update(11'd720, 15'(0), 14'd4000);
		send_update(11'd720, 15'(0), 14'd4500);
		send_update(11'd720, 15'(0), 14'd6000);
		c.mode = MODE_DRY;
		settle();
		load_settings(c);
		send_update(11'd1439, 15'(0), 14'd11000);
		send_update(11'd1439, 15'(0), 14'd10500);
	endtask

	// mode codes outside the list drive the fan to zero
	task automatic test_unused_modes();
		climate_cfg_t c;
		c = power_on_cfg();
		c.max_pair = 14'h3FFF;
		c.mode     = MODE_UNUSED_LO;
		settle();
		load_settings(c);
		send_update(11'd720, 15'(2000), 14'd5000);
		c.mode = MODE_UNUSED_HI;
		settle();
		load_settings(c);
		send_update(11'd720, 15'(2000), 14'd5000);
	endtask

	// fresh random register set per phase, idle pressure varied per phase
	task automatic test_random_settings(input int phases, input int per_phase);
		climate_cfg_t c;
		for (int p = 0; p < phases; p++) begin
			c = random_settings();
			settle();
			source_idle_rate = pick_rate();
			sink_idle_rate   = pick_rate();
			load_settings(c);
			stream_updates(c, per_phase);
		end
	endtask

	// closing stretch at full rate, no idling on either side
	task automatic test_steady_stream(input int count);
		climate_cfg_t c;
		c = random_settings();
		c.mode = 3'($urandom_range(MODE_DRY, MODE_HEAT));
		settle();
		source_idle_rate = 0;
		sink_idle_rate   = 0;
		load_settings(c);
		stream_updates(c, count);
	endtask

	initial begin
		arst_n   = 1'b0;
		wr_en    = 1'b0;
		wr_index = REG_FAN_MODE;
		wr_data  = '0;
		update_bus.valid       = 1'b0;
		update_bus.time_of_day = '0;
		update_bus.temperature = '0;
		update_bus.humidity    = '0;
		live_cfg = power_on_cfg();

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_power_on_defaults();
		test_follow_maximum();
		test_temperature_stepping();
		test_humidity_stepping();
		test_unused_modes();
		test_random_settings(8, 45);
		test_steady_stream(60);

		// drain, then a few cycles for anything stray to show up
		settle();
		repeat (8) @(negedge clk);

		$display("covered %0d updates, %0d drive results checked, %0d register sets loaded",
			updates_sent, results_checked, settings_loaded);
		$display("all fan modes incl. unused codes, day/night edges, field extremes, %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
